// ----- rtl/core/assert_macros.svh -----
// Assertion wrappers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_DIS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_ALW(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_DIS(lbl, clk, rst, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif

`endif

// ----- rtl/core/gpe_pkg.sv -----
package gpe_pkg;

   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_ROWS  = 16;
   localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);

   localparam int MAX_COLS    = 8;
   localparam int COL_CNT_W   = 4;
   localparam int XOFF_W      = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DRAW = 1'b1;

   typedef enum logic [1:0] {
      FMT_16BPP = 2'd0,
      FMT_24BPP = 2'd1,
      FMT_32BPP = 2'd2,
      FMT_NONE  = 2'd3
   } pix_fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FB_BASE    = 3'd0,
      CSR_LINE_PITCH = 3'd1,
      CSR_SCREEN_W   = 3'd2,
      CSR_SCREEN_H   = 3'd3,
      CSR_PIX_FMT    = 3'd4,
      CSR_GLYPH_W    = 3'd5
   } csr_index_type;

   // One glyph row ready to walk: bits are MSB aligned, count is columns left.
   typedef struct packed {
      logic [31:0]          row_base;
      logic [XOFF_W-1:0]    xoff;
      logic [7:0]           bits;
      logic [COL_CNT_W-1:0] count;
      logic [2:0]           bytes;
      logic [31:0]          fg;
      logic [31:0]          bg;
   } gpe_job_type;

endpackage

// ----- rtl/core/gpe_font_ram.sv -----
module gpe_font_ram
   import gpe_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [FONT_ADDR_W-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic                   rd_en,
   input  logic [FONT_ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [FONT_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gpe_pixel_gen.sv -----
`include "assert_macros.svh"

module gpe_pixel_gen
   import gpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  gpe_job_type job,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_byte_address,
   output logic [31:0] rsp_write_data,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last
);

   logic        busy_ff, busy_in;
   gpe_job_type cur_ff, cur_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic [31:0] out_data_ff, out_data_in;
   logic [2:0]  out_bytes_ff, out_bytes_in;
   logic        out_last_ff, out_last_in;

   logic emit;
   logic final_col;
   logic load;

   assign emit      = busy_ff && (!out_valid_ff || rsp_ready);
   assign final_col = emit && (cur_ff.count == COL_CNT_W'(1));
   assign job_ready = !busy_ff || final_col;
   assign load      = job_valid && job_ready;

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      if (emit) begin
         cur_in.count = cur_ff.count - COL_CNT_W'(1);
         cur_in.bits  = {cur_ff.bits[6:0], 1'b0};
         cur_in.xoff  = cur_ff.xoff + XOFF_W'(cur_ff.bytes);
      end
      if (final_col) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         cur_in  = job;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_addr_in  = out_addr_ff;
      out_data_in  = out_data_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = cur_ff.row_base + 32'(cur_ff.xoff);
         out_data_in  = cur_ff.bits[7] ? cur_ff.fg : cur_ff.bg;
         out_bytes_in = cur_ff.bytes;
         out_last_in  = (cur_ff.count == COL_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_addr_ff  <= out_addr_in;
      out_data_ff  <= out_data_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_address = out_addr_ff;
   assign rsp_write_data   = out_data_ff;
   assign rsp_byte_count   = out_bytes_ff;
   assign rsp_last         = out_last_ff;

   `ASSERT_DIS(a_busy_has_cols, clock, reset, busy_ff |-> cur_ff.count != '0)
   `ASSERT_DIS(a_final_marks_last, clock, reset, final_col |=> rsp_valid && rsp_last)
   `ASSERT_DIS(a_mid_not_last, clock, reset, emit && !final_col |=> busy_ff && !rsp_last)

endmodule

// ----- rtl/core/glyph_row_pixel_expander_unit.sv -----
// Glyph row pixel expander.
// Request channel (req_*, valid/ready): mode 0 loads one font row byte into
// the 4096-entry font memory; mode 1 draws one glyph row at an origin.
// Response channel (rsp_*, valid/ready): one framebuffer write per visible
// pixel, left to right, rsp_last set on the final write of a draw.
// Config port (csr_*): write enable, register index, 32-bit data, no wait.
// Draws pass the draw stage, the column walker and its output register.
// Throughput: one pixel write per cycle unless the response port stalls;
// a draw of N visible pixels (up to 8) is walked by the single column walker.
// A new request is taken while the previous row is still being walked; a
// load is written when taken; clipped or empty draws skip the walker.
// Font memory: one synchronous port for loads and one for draw reads; a load
// is visible to any draw accepted after it.
// Reset clears the pipeline and config registers, not the font memory.
// A stalled response port holds its word and backs up to req_ready.
`include "assert_macros.svh"

module glyph_row_pixel_expander_unit
   import gpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [7:0]            req_glyph_index,
   input  logic [3:0]            req_glyph_row,
   input  logic [7:0]            req_font_byte,
   input  logic [11:0]           req_origin_x,
   input  logic [11:0]           req_origin_y,
   input  logic [31:0]           req_fg_color,
   input  logic [31:0]           req_bg_color,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_byte_address,
   output logic [31:0]           rsp_write_data,
   output logic [2:0]            rsp_byte_count,
   output logic                  rsp_last
);

   // Config registers
   logic [31:0] fb_base_ff, fb_base_in;
   logic [15:0] line_pitch_ff, line_pitch_in;
   logic [12:0] screen_w_ff, screen_w_in;
   logic [12:0] screen_h_ff, screen_h_in;
   pix_fmt_type pix_fmt_ff, pix_fmt_in;
   logic [3:0]  glyph_w_ff, glyph_w_in;

   always_comb begin
      fb_base_in    = fb_base_ff;
      line_pitch_in = line_pitch_ff;
      screen_w_in   = screen_w_ff;
      screen_h_in   = screen_h_ff;
      pix_fmt_in    = pix_fmt_ff;
      glyph_w_in    = glyph_w_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FB_BASE:    fb_base_in    = csr_wdata;
            CSR_LINE_PITCH: line_pitch_in = csr_wdata[15:0];
            CSR_SCREEN_W:   screen_w_in   = csr_wdata[12:0];
            CSR_SCREEN_H:   screen_h_in   = csr_wdata[12:0];
            CSR_PIX_FMT:    pix_fmt_in    = pix_fmt_type'(csr_wdata[1:0]);
            CSR_GLYPH_W:    glyph_w_in    = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_base_ff    <= '0;
         line_pitch_ff <= '0;
         screen_w_ff   <= '0;
         screen_h_ff   <= '0;
         pix_fmt_ff    <= FMT_32BPP;
         glyph_w_ff    <= 4'(MAX_COLS);
      end else begin
         fb_base_ff    <= fb_base_in;
         line_pitch_ff <= line_pitch_in;
         screen_w_ff   <= screen_w_in;
         screen_h_ff   <= screen_h_in;
         pix_fmt_ff    <= pix_fmt_in;
         glyph_w_ff    <= glyph_w_in;
      end
   end

   // Request accept and font memory access
   logic                   req_take;
   logic                   draw_take;
   logic                   job_take;
   logic                   job_valid;
   logic                   job_ready;
   logic [FONT_ADDR_W-1:0] font_addr;
   logic [7:0]             font_rd;

   assign req_take  = req_valid && req_ready;
   assign draw_take = req_take && (req_mode == MODE_DRAW);
   assign font_addr = FONT_ADDR_W'(req_glyph_index) * FONT_ADDR_W'(GLYPH_ROWS)
                    + FONT_ADDR_W'(req_glyph_row);

   gpe_font_ram u_font_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_mode == MODE_LOAD)),
      .wr_addr (font_addr),
      .wr_data (req_font_byte),
      .rd_en   (draw_take),
      .rd_addr (font_addr),
      .rd_data (font_rd)
   );

   // Draw stage: font byte arrives from memory, parameters held here
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_row_ff;
   logic [11:0] s1_ox_ff;
   logic [11:0] s1_oy_ff;
   logic [31:0] s1_fg_ff;
   logic [31:0] s1_bg_ff;

   assign req_ready   = !s1_valid_ff || job_take;
   assign s1_valid_in = draw_take || (s1_valid_ff && !job_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (draw_take) begin
         s1_row_ff <= req_glyph_row;
         s1_ox_ff  <= req_origin_x;
         s1_oy_ff  <= req_origin_y;
         s1_fg_ff  <= req_fg_color;
         s1_bg_ff  <= req_bg_color;
      end
   end

   logic [12:0]          y_pos;
   logic [12:0]          ox_wide;
   logic [12:0]          visible;
   logic [COL_CNT_W-1:0] cols;
   logic [COL_CNT_W-1:0] n_cols;
   logic [28:0]          row_prod;
   logic [XOFF_W-1:0]    ox_x;
   logic [XOFF_W-1:0]    xoff_start;
   logic [2:0]           bytes;
   gpe_job_type          job;

   assign y_pos    = 13'(s1_oy_ff) + 13'(s1_row_ff);
   assign ox_wide  = 13'(s1_ox_ff);
   assign visible  = (screen_w_ff > ox_wide) ? (screen_w_ff - ox_wide) : '0;
   assign cols     = (glyph_w_ff > COL_CNT_W'(MAX_COLS)) ? COL_CNT_W'(MAX_COLS) : glyph_w_ff;
   assign row_prod = 29'(y_pos) * 29'(line_pitch_ff);
   assign ox_x     = XOFF_W'(s1_ox_ff);

   always_comb begin
      unique case (pix_fmt_ff)
         FMT_16BPP: begin
            bytes      = 3'd2;
            xoff_start = ox_x + ox_x;
         end
         FMT_24BPP: begin
            bytes      = 3'd3;
            xoff_start = ox_x + ox_x + ox_x;
         end
         FMT_32BPP: begin
            bytes      = 3'd4;
            xoff_start = {ox_x[XOFF_W-3:0], 2'b00};
         end
         FMT_NONE: begin
            bytes      = 3'd4;
            xoff_start = '0;
         end
      endcase
   end

   // Visible columns form a prefix of the row, so a count is enough.
   always_comb begin
      priority if (pix_fmt_ff == FMT_NONE || y_pos >= screen_h_ff) begin
         n_cols = '0;
      end else if (visible < 13'(cols)) begin
         n_cols = visible[COL_CNT_W-1:0];
      end else begin
         n_cols = cols;
      end
   end

   always_comb begin
      job.row_base = fb_base_ff + 32'(row_prod);
      job.xoff     = xoff_start;
      job.bits     = font_rd << (COL_CNT_W'(MAX_COLS) - cols);
      job.count    = n_cols;
      job.bytes    = bytes;
      job.fg       = s1_fg_ff;
      job.bg       = s1_bg_ff;
   end

   // Drop rows with nothing to write right here.
   assign job_valid = s1_valid_ff && (n_cols != '0);
   assign job_take  = s1_valid_ff && ((n_cols == '0) || job_ready);

   gpe_pixel_gen u_pixel_gen (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job_ready        (job_ready),
      .job              (job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_address (rsp_byte_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last         (rsp_last)
   );

   `ASSERT_DIS(a_s1_holds, clock, reset, s1_valid_ff && !job_take |=> s1_valid_ff)
   `ASSERT_DIS(a_load_skips_s1, clock, reset, req_take && req_mode == MODE_LOAD |=> !s1_valid_ff)
   `ASSERT_DIS(a_draw_enters_s1, clock, reset, draw_take |=> s1_valid_ff)

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import gpe_pkg::*;

   typedef struct packed {
      logic        mode;
      logic [7:0]  gidx;
      logic [3:0]  grow;
      logic [7:0]  fbyte;
      logic [11:0] ox;
      logic [11:0] oy;
      logic [31:0] fg;
      logic [31:0] bg;
   } glyph_req_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] data;
      logic [2:0]  count;
      logic        last;
   } pixel_write_type;

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   // typed_n < 0: take the expansion from the predictor
   typedef struct {
      row_kind_type    kind;
      csr_index_type   idx;
      logic [31:0]     value;
      glyph_req_type   req;
      int              typed_n;
      pixel_write_type typed_w;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = 1'b0;
   logic [7:0]            req_glyph_index = '0;
   logic [3:0]            req_glyph_row = '0;
   logic [7:0]            req_font_byte = '0;
   logic [11:0]           req_origin_x = '0;
   logic [11:0]           req_origin_y = '0;
   logic [31:0]           req_fg_color = '0;
   logic [31:0]           req_bg_color = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_byte_address;
   logic [31:0]           rsp_write_data;
   logic [2:0]            rsp_byte_count;
   logic                  rsp_last;

   glyph_row_pixel_expander_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_glyph_index  (req_glyph_index),
      .req_glyph_row    (req_glyph_row),
      .req_font_byte    (req_font_byte),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_fg_color     (req_fg_color),
      .req_bg_color     (req_bg_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_address (rsp_byte_address),
      .rsp_write_data   (rsp_write_data),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last         (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("FAIL glyph_row_pixel_expander_unit");
      $finish;
   end

   // shadow of the register file and the font memory
   logic [31:0]  cfg_base = 32'd0;
   logic [15:0]  cfg_pitch = 16'd0;
   logic [12:0]  cfg_sw = 13'd0;
   logic [12:0]  cfg_sh = 13'd0;
   pix_fmt_type  cfg_fmt = FMT_32BPP;
   logic [3:0]   cfg_gw = 4'd8;

   logic [7:0]   glyph_bytes [FONT_DEPTH];
   bit           glyph_known [FONT_DEPTH];
   int           known_slots [$];

   pixel_write_type row_writes [$];
   pixel_write_type due_writes [$];
   int              mismatches = 0;
   int              checked_writes = 0;
   int              burst_left = 5;
   int              stall_left = 0;
   int              stall_style = 0;
   plan_row_type    plan [$];

   function automatic void flag(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%s", msg);
   endfunction

   // Fill row_writes with the pixel writes one word causes.
   function automatic void expand_row(input glyph_req_type r);
      int              slot;
      logic [12:0]     y;
      logic [12:0]     x;
      logic [3:0]      cols;
      logic [2:0]      nbytes;
      logic [7:0]      bits;
      pixel_write_type w;
      row_writes.delete();
      slot = int'(r.gidx) * GLYPH_ROWS + int'(r.grow);
      if (r.mode == MODE_LOAD) begin
         glyph_bytes[slot] = r.fbyte;
         if (!glyph_known[slot]) begin
            glyph_known[slot] = 1'b1;
            known_slots.push_back(slot);
         end
         return;
      end
      case (cfg_fmt)
         FMT_16BPP: nbytes = 3'd2;
         FMT_24BPP: nbytes = 3'd3;
         FMT_32BPP: nbytes = 3'd4;
         default:   return;
      endcase
      cols = (cfg_gw > 4'd8) ? 4'd8 : cfg_gw;
      bits = glyph_bytes[slot];
      y = {1'b0, r.oy} + {9'd0, r.grow};
      if (y >= cfg_sh)
         return;
      for (int c = 0; c < int'(cols); c++) begin
         x = {1'b0, r.ox} + 13'(c);
         if (x >= cfg_sw)
            continue;
         w.addr  = cfg_base + 32'(y) * 32'(cfg_pitch) + 32'(x) * 32'(nbytes);
         w.data  = bits[int'(cols) - 1 - c] ? r.fg : r.bg;
         w.count = nbytes;
         w.last  = 1'b0;
         row_writes.push_back(w);
      end
      if (row_writes.size() > 0)
         row_writes[row_writes.size() - 1].last = 1'b1;
   endfunction

   function automatic plan_row_type csr_step(input csr_index_type idx, input logic [31:0] value);
      plan_row_type p;
      p.kind = ROW_CSR;
      p.idx = idx;
      p.value = value;
      p.req = '0;
      p.typed_n = -1;
      p.typed_w = '0;
      return p;
   endfunction

   function automatic plan_row_type load_step(input logic [7:0] g, input logic [3:0] r,
                                              input logic [7:0] b);
      plan_row_type p;
      p = csr_step(CSR_FB_BASE, 32'd0);
      p.kind = ROW_ITEM;
      p.req = {MODE_LOAD, g, r, b, 12'($urandom), 12'($urandom), 32'($urandom),
               32'($urandom)};
      return p;
   endfunction

   function automatic plan_row_type draw_step(input logic [7:0] g, input logic [3:0] r,
                                              input logic [11:0] ox, input logic [11:0] oy,
                                              input logic [31:0] fg, input logic [31:0] bg,
                                              input int n, input pixel_write_type w);
      plan_row_type p;
      p = csr_step(CSR_FB_BASE, 32'd0);
      p.kind = ROW_ITEM;
      p.req = {MODE_DRAW, g, r, 8'($urandom), ox, oy, fg, bg};
      p.typed_n = n;
      p.typed_w = w;
      return p;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (due_writes.size() != 0)
         @(posedge clock);
      // empty and clipped rows leave nothing to wait on, so give the pipe time
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FB_BASE:    cfg_base = value;
         CSR_LINE_PITCH: cfg_pitch = value[15:0];
         CSR_SCREEN_W:   cfg_sw = value[12:0];
         CSR_SCREEN_H:   cfg_sh = value[12:0];
         CSR_PIX_FMT:    cfg_fmt = pix_fmt_type'(value[1:0]);
         CSR_GLYPH_W:    cfg_gw = value[3:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the word until taken, then book its writes; valid stays up inside a burst.
   task automatic send_word(input glyph_req_type r, input int typed_n,
                            input pixel_write_type typed_w);
      req_valid <= 1'b1;
      req_mode <= r.mode;
      req_glyph_index <= r.gidx;
      req_glyph_row <= r.grow;
      req_font_byte <= r.fbyte;
      req_origin_x <= r.ox;
      req_origin_y <= r.oy;
      req_fg_color <= r.fg;
      req_bg_color <= r.bg;
      do
         @(posedge clock);
      while (!req_ready);
      expand_row(r);
      if (typed_n < 0)
         foreach (row_writes[i])
            due_writes.push_back(row_writes[i]);
      else if (typed_n == 1)
         due_writes.push_back(typed_w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      pixel_write_type got;
      pixel_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_byte_address, rsp_write_data, rsp_byte_count, rsp_last};
         if (due_writes.size() == 0) begin
            flag($sformatf("unexpected write: addr %h data %h count %0d last %b",
                           got.addr, got.data, got.count, got.last));
         end else begin
            want = due_writes.pop_front();
            if (got != want)
               flag($sformatf({"write %0d: expected addr %h data %h count %0d last %b,",
                               " got addr %h data %h count %0d last %b"},
                              checked_writes, want.addr, want.data, want.count, want.last,
                              got.addr, got.data, got.count, got.last));
         end
         checked_writes++;
      end
   end

   initial begin
      glyph_req_type req;
      int            slot;

      plan.push_back(load_step(8'd0, 4'd0, 8'hA5));
      plan.push_back(load_step(8'd255, 4'd15, 8'hFF));
      plan.push_back(load_step(8'd127, 4'd7, 8'h00));
      plan.push_back(load_step(8'd128, 4'd8, 8'h81));
      plan.push_back(load_step(8'd1, 4'd1, 8'h5A));
      // reset screen is 0 x 0: everything clipped
      plan.push_back(draw_step(8'd0, 4'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, 0, '0));
      plan.push_back(csr_step(CSR_SCREEN_W, 32'hFFFF_FFFF));
      plan.push_back(csr_step(CSR_SCREEN_H, 32'hFFFF_FFFF));
      plan.push_back(csr_step(CSR_FB_BASE, 32'h0000_1000));
      plan.push_back(csr_step(CSR_LINE_PITCH, 32'h0000_0100));
      plan.push_back(draw_step(8'd0, 4'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, -1, '0));
      plan.push_back(csr_step(CSR_GLYPH_W, 32'd1));
      plan.push_back(draw_step(8'd255, 4'd15, 12'd1, 12'd1, 32'h1234_5678, 32'h0, 1,
                               '{32'h0000_2004, 32'h1234_5678, 3'd4, 1'b1}));
      plan.push_back(draw_step(8'd127, 4'd7, 12'd2, 12'd0, 32'h1, 32'hCAFE_BABE, 1,
                               '{32'h0000_1708, 32'hCAFE_BABE, 3'd4, 1'b1}));
      plan.push_back(csr_step(CSR_PIX_FMT, 32'(FMT_NONE)));
      plan.push_back(draw_step(8'd255, 4'd15, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, 0, '0));
      plan.push_back(csr_step(CSR_PIX_FMT, 32'(FMT_16BPP)));
      plan.push_back(csr_step(CSR_GLYPH_W, 32'd0));
      plan.push_back(draw_step(8'd255, 4'd15, 12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0, 0, '0));
      // widths above eight saturate
      plan.push_back(csr_step(CSR_GLYPH_W, 32'd15));
      plan.push_back(draw_step(8'd128, 4'd8, 12'd4095, 12'd4095, 32'h0000_F00F,
                               32'hFFFF_0FF0, -1, '0));
      plan.push_back(csr_step(CSR_PIX_FMT, 32'(FMT_24BPP)));
      plan.push_back(csr_step(CSR_FB_BASE, 32'hFFFF_FFF0));
      plan.push_back(csr_step(CSR_LINE_PITCH, 32'h0000_FFFF));
      plan.push_back(csr_step(CSR_GLYPH_W, 32'd8));
      plan.push_back(draw_step(8'd1, 4'd1, 12'd4095, 12'd4095, 32'h00AB_CDEF, 32'h0012_3456,
                               -1, '0));
      plan.push_back(csr_step(CSR_SCREEN_W, 32'd4));
      plan.push_back(csr_step(CSR_SCREEN_H, 32'd16));
      plan.push_back(draw_step(8'd0, 4'd0, 12'd0, 12'd0, 32'h0055_AA55, 32'h00AA_55AA, -1, '0));
      plan.push_back(draw_step(8'd0, 4'd0, 12'd0, 12'd16, 32'h1, 32'h2, 0, '0));
      plan.push_back(draw_step(8'd0, 4'd0, 12'd4, 12'd0, 32'h1, 32'h2, 0, '0));
      plan.push_back(draw_step(8'd255, 4'd15, 12'd3, 12'd0, 32'h0077_7777, 32'h0, -1, '0));
      plan.push_back(draw_step(8'd255, 4'd15, 12'd0, 12'd1, 32'h1, 32'h2, 0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_csr(plan[i].idx, plan[i].value);
         end else begin
            send_word(plan[i].req, plan[i].typed_n, plan[i].typed_w);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case ($urandom_range(0, 2))
            0:       write_csr(CSR_FB_BASE, 32'd0);
            1:       write_csr(CSR_FB_BASE, 32'hFFFF_FFFF);
            default: write_csr(CSR_FB_BASE, $urandom);
         endcase
         case ($urandom_range(0, 2))
            0:       write_csr(CSR_LINE_PITCH, 32'd0);
            1:       write_csr(CSR_LINE_PITCH, 32'h0000_FFFF);
            default: write_csr(CSR_LINE_PITCH, 32'($urandom_range(0, 65535)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_SCREEN_W, 32'd0);
            1:       write_csr(CSR_SCREEN_W, 32'd8191);
            2:       write_csr(CSR_SCREEN_W, 32'($urandom_range(1, 40)));
            default: write_csr(CSR_SCREEN_W, 32'($urandom_range(0, 8191)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_SCREEN_H, 32'd4096);
            1:       write_csr(CSR_SCREEN_H, 32'd8191);
            2:       write_csr(CSR_SCREEN_H, 32'($urandom_range(1, 40)));
            default: write_csr(CSR_SCREEN_H, 32'($urandom_range(0, 8191)));
         endcase
         if ($urandom_range(0, 7) == 0)
            write_csr(CSR_PIX_FMT, 32'(FMT_NONE));
         else
            write_csr(CSR_PIX_FMT, 32'($urandom_range(0, 2)));
         write_csr(CSR_GLYPH_W, 32'($urandom_range(0, 15)));

         for (int k = 0; k < 19; k++) begin
            if (phase == 2 && k == 11)
               drain();
            req = {$urandom, $urandom, $urandom};
            if ($urandom_range(0, 99) < 35) begin
               req.mode = MODE_LOAD;
               req.gidx = 8'($urandom);
               req.grow = 4'($urandom);
            end else begin
               req.mode = MODE_DRAW;
               // draw only rows that hold a loaded byte
               slot = known_slots[$urandom_range(0, known_slots.size() - 1)];
               req.gidx = 8'(slot / GLYPH_ROWS);
               req.grow = 4'(slot % GLYPH_ROWS);
               if ($urandom_range(0, 1))
                  req.ox = 12'($urandom_range(0, 24));
               if ($urandom_range(0, 1))
                  req.oy = 12'($urandom_range(0, 24));
            end
            send_word(req, -1, '0);
         end
      end

      drain();
      if (mismatches == 0)
         $display("PASS glyph_row_pixel_expander_unit");
      else
         $display("FAIL glyph_row_pixel_expander_unit");
      $finish;
   end

endmodule
